// ===== src/mmae_pkg.sv =====
// Shared types and constants for the matrix multiply-add engine.
`default_nettype none
package mmae_pkg;

    localparam int MAX_DIM = 8;
    localparam int IDX_W   = $clog2(MAX_DIM);
    localparam int ADDR_W  = 2 * IDX_W;
    localparam int DATA_W  = 32;
    localparam int DIM_W   = 4;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] ACT_WR_A    = 2'd0;
    localparam logic [1:0] ACT_WR_B    = 2'd1;
    localparam logic [1:0] ACT_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_A = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_B = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B = 3'd4;

    localparam logic MODE_MUL = 1'b0;
    localparam logic MODE_ADD = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic [1:0]               action;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic                     status;
        logic [IDX_W-1:0]         out_row;
        logic [IDX_W-1:0]         out_col;
        logic signed [DATA_W-1:0] element;
        logic                     last;
    } t_out_item;

    // control that travels with each operand pair through the MAC pipeline
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last_k;
        logic             last_run;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_tag;

endpackage
`default_nettype wire

// ===== src/mmae_mac.sv =====
// Shared multiply-or-add unit with accumulator, two register stages.
`default_nettype none
module mmae_mac (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_add,
    input  wire logic signed [mmae_pkg::DATA_W-1:0] i_a,
    input  wire logic signed [mmae_pkg::DATA_W-1:0] i_b,
    input  wire mmae_pkg::t_tag               i_tag,
    output mmae_pkg::t_tag                    o_tag,
    output logic signed [mmae_pkg::DATA_W-1:0] o_acc,
    output logic                              o_busy
);
    import mmae_pkg::*;

    logic signed [DATA_W-1:0]   w_prod;
    logic signed [DATA_W-1:0]   n_p;
    logic signed [DATA_W-1:0]   r_p;
    logic signed [DATA_W-1:0]   n_acc;
    logic signed [DATA_W-1:0]   r_acc;
    t_tag                       r_tag2;
    t_tag                       r_tag3;

    assign w_prod = i_a * i_b;
    // low word of the product is the same for signed or unsigned operands
    assign n_p    = i_add ? (i_a + i_b) : w_prod;
    assign n_acc  = r_tag2.first ? r_p : (r_acc + r_p);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag2.valid <= 1'b0;
            r_tag3.valid <= 1'b0;
        end else begin
            r_tag2.valid <= i_tag.valid;
            r_tag3.valid <= r_tag2.valid;
        end
        r_p                <= n_p;
        r_tag2.first       <= i_tag.first;
        r_tag2.last_k      <= i_tag.last_k;
        r_tag2.last_run    <= i_tag.last_run;
        r_tag2.row         <= i_tag.row;
        r_tag2.col         <= i_tag.col;
        r_tag3.first       <= r_tag2.first;
        r_tag3.last_k      <= r_tag2.last_k;
        r_tag3.last_run    <= r_tag2.last_run;
        r_tag3.row         <= r_tag2.row;
        r_tag3.col         <= r_tag2.col;
        if (r_tag2.valid) begin
            r_acc <= n_acc;
        end
    end

    assign o_tag  = r_tag3;
    assign o_acc  = r_acc;
    assign o_busy = r_tag2.valid;

endmodule
`default_nettype wire

// ===== src/matrix_multiply_add_engine_core.sv =====
// Top level of the matrix multiply-add engine: stores, sequencer, output.
//
// Usage: configure mode and the four dimension registers through the write
// port (i_cfg_we, i_cfg_idx, i_cfg_data) while busy is low. Items are offered
// on i_item with start; one is accepted at an edge where start is high and
// busy is low. Action write-A / write-B stores one element and
// leaves busy low. A compute item raises busy and runs the shared MAC unit
// once per (row, col, k) step, reading one word of each store per cycle:
//   multiply: rows_a * cols_b * cols_a steps
//   add:      rows_a * cols_a steps
// Result words come row-major, one per result (row, col), last set on the final one.
// A bad dimension gives a single error word in the cycle after acceptance.
// Each result word is on o_result for one cycle with o_strobe; the receiver
// cannot stall. Reset returns the registers to mode multiply and all sizes 1
// and clears the sequencer; store contents are undefined until written.
`default_nettype none
module matrix_multiply_add_engine_core (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  start,
    output logic                                 busy,
    input  wire mmae_pkg::t_in_item              i_item,
    output logic                                 o_strobe,
    output mmae_pkg::t_out_item                  o_result,
    input  wire                                  i_cfg_we,
    input  wire logic [mmae_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [mmae_pkg::DIM_W-1:0]      i_cfg_data
);
    import mmae_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    // configuration
    logic             r_mode;
    logic [DIM_W-1:0] r_rows_a;
    logic [DIM_W-1:0] r_cols_a;
    logic [DIM_W-1:0] r_rows_b;
    logic [DIM_W-1:0] r_cols_b;

    // stores
    logic [DATA_W-1:0] r_store_a [MAX_DIM*MAX_DIM];
    logic [DATA_W-1:0] r_store_b [MAX_DIM*MAX_DIM];
    logic signed [DATA_W-1:0] r_rd_a;
    logic signed [DATA_W-1:0] r_rd_b;

    // sequencer
    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic             r_add;
    logic [IDX_W-1:0] r_nr;
    logic [IDX_W-1:0] r_nc;
    logic [IDX_W-1:0] r_nk;
    logic [IDX_W-1:0] r_i;
    logic [IDX_W-1:0] r_j;
    logic [IDX_W-1:0] r_k;
    t_tag             r_s1;
    logic             r_err;

    logic             w_accept;
    logic             w_dims_ok;
    logic             w_go;
    logic             w_issue;
    logic             w_end_k;
    logic             w_end_j;
    logic             w_end_i;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [ADDR_W-1:0] w_addr_a;
    logic [ADDR_W-1:0] w_addr_b;
    logic [DIM_W-1:0]  w_nr;
    logic [DIM_W-1:0]  w_nc;
    logic [DIM_W-1:0]  w_nk;

    t_tag                     w_mac_tag;
    logic signed [DATA_W-1:0] w_mac_acc;
    logic                     w_mac_busy;
    logic                     w_mac_strobe;

    function automatic logic dim_ok(input logic [DIM_W-1:0] d);
        dim_ok = (d != '0) && (d <= DIM_W'(MAX_DIM));
    endfunction

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;

    assign w_dims_ok = dim_ok(r_rows_a) && dim_ok(r_cols_a) && dim_ok(r_rows_b)
                    && dim_ok(r_cols_b)
                    && ((r_mode == MODE_MUL) ? (r_cols_a == r_rows_b)
                                             : (r_rows_a == r_rows_b
                                                && r_cols_a == r_cols_b));
    assign w_go = w_accept && (i_item.action == ACT_COMPUTE);

    assign w_nr = r_rows_a - DIM_W'(1);
    assign w_nc = ((r_mode == MODE_MUL) ? r_cols_b : r_cols_a) - DIM_W'(1);
    assign w_nk = (r_mode == MODE_MUL) ? (r_cols_a - DIM_W'(1)) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_MUL;
            r_rows_a <= DIM_W'(1);
            r_cols_a <= DIM_W'(1);
            r_rows_b <= DIM_W'(1);
            r_cols_b <= DIM_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE:   r_mode   <= i_cfg_data[0];
                CFG_ROWS_A: r_rows_a <= i_cfg_data;
                CFG_COLS_A: r_cols_a <= i_cfg_data;
                CFG_ROWS_B: r_rows_b <= i_cfg_data;
                CFG_COLS_B: r_cols_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // store write and read ports
    assign w_wr_addr = {i_item.row, i_item.col};
    assign w_addr_a  = r_add ? {r_i, r_j} : {r_i, r_k};
    assign w_addr_b  = r_add ? {r_i, r_j} : {r_k, r_j};

    always_ff @(posedge i_clk) begin
        if (w_accept && i_item.action == ACT_WR_A) begin
            r_store_a[w_wr_addr] <= i_item.value;
        end
        r_rd_a <= r_store_a[w_addr_a];
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_item.action == ACT_WR_B) begin
            r_store_b[w_wr_addr] <= i_item.value;
        end
        r_rd_b <= r_store_b[w_addr_b];
    end

    // index walk: k innermost, then column, then row
    assign w_issue = (r_state == ST_RUN);
    assign w_end_k = (r_k == r_nk);
    assign w_end_j = (r_j == r_nc);
    assign w_end_i = (r_i == r_nr);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_go && w_dims_ok) n_state = ST_RUN;
            ST_RUN:   if (w_end_k && w_end_j && w_end_i) n_state = ST_DRAIN;
            ST_DRAIN: if (!r_s1.valid && !w_mac_busy) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_s1.valid <= 1'b0;
            r_err      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_s1.valid <= w_issue;
            r_err      <= w_go && !w_dims_ok;
        end
        r_s1.first    <= (r_k == '0);
        r_s1.last_k   <= w_end_k;
        r_s1.last_run <= w_end_k && w_end_j && w_end_i;
        r_s1.row      <= r_i;
        r_s1.col      <= r_j;
        if (r_state == ST_IDLE && w_go) begin
            r_add <= (r_mode == MODE_ADD);
            r_nr  <= w_nr[IDX_W-1:0];
            r_nc  <= w_nc[IDX_W-1:0];
            r_nk  <= w_nk[IDX_W-1:0];
            r_i   <= '0;
            r_j   <= '0;
            r_k   <= '0;
        end else if (w_issue) begin
            if (w_end_k) begin
                r_k <= '0;
                if (w_end_j) begin
                    r_j <= '0;
                    r_i <= r_i + IDX_W'(1);
                end else begin
                    r_j <= r_j + IDX_W'(1);
                end
            end else begin
                r_k <= r_k + IDX_W'(1);
            end
        end
    end

    mmae_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_add   (r_add),
        .i_a     (r_rd_a),
        .i_b     (r_rd_b),
        .i_tag   (r_s1),
        .o_tag   (w_mac_tag),
        .o_acc   (w_mac_acc),
        .o_busy  (w_mac_busy)
    );

    assign w_mac_strobe = w_mac_tag.valid && w_mac_tag.last_k;
    assign o_strobe     = w_mac_strobe || r_err;

    always_comb begin
        if (r_err) begin
            o_result.status  = STATUS_ERR;
            o_result.out_row = '0;
            o_result.out_col = '0;
            o_result.element = '0;
            o_result.last    = 1'b1;
        end else begin
            o_result.status  = STATUS_OK;
            o_result.out_row = w_mac_tag.row;
            o_result.out_col = w_mac_tag.col;
            o_result.element = w_mac_acc;
            o_result.last    = w_mac_tag.last_run;
        end
    end

    a_no_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_err && w_mac_strobe))
        else $error("error word collides with a MAC result word");

    a_idle_no_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |=> !r_s1.valid)
        else $error("operand pair issued while idle");

    a_busy_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without an accepted item");

    a_done_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> (!r_s1.valid && !w_mac_busy))
        else $error("busy fell with words still in the pipeline");

endmodule
`default_nettype wire
